@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the path query block.
// Depends on nothing; under SYNTHESIS the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/tpq_pkg.sv @@
// Package for the tree path min/max query block: field widths, sentinels,
// sequencer states and the lift-table port structs. Depends on nothing.
package tpq_pkg;

   localparam int ID_W      = 10;
   localparam int ID_SPAN   = 1 << ID_W;
   localparam int DEPTH_W   = 10;
   localparam int WEIGHT_W  = 31;
   localparam int LVL_MAX_W = 5;
   localparam int RED_J_W   = 4;
   localparam int SHIFT_W   = 32;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_INF  = 31'sd1073741823;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_NINF = -31'sd1073741823;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_LD_DEP,
      ST_LD_BASE,
      ST_LD_RD,
      ST_LD_WR,
      ST_Q_DEP,
      ST_Q_ORDER,
      ST_Q_CLIMB,
      ST_Q_CLIMB_USE,
      ST_Q_LIFT_RD,
      ST_Q_LIFT_USE,
      ST_Q_TAIL_RD,
      ST_Q_TAIL_USE,
      ST_DONE
   } tpq_state_type;

   typedef struct packed {
      logic [ID_W-1:0]            anc;
      logic signed [WEIGHT_W-1:0] wmax;
      logic signed [WEIGHT_W-1:0] wmin;
   } tpq_entry_type;

   typedef struct packed {
      logic                 tab_wr;
      logic                 dep_wr;
      logic [ID_W-1:0]      wr_node;
      logic [LVL_MAX_W-1:0] wr_level;
      tpq_entry_type        wr_entry;
      logic [DEPTH_W-1:0]   dep_wr_val;
      logic [ID_W-1:0]      rd_a_node;
      logic [LVL_MAX_W-1:0] rd_a_level;
      logic [ID_W-1:0]      rd_b_node;
      logic [LVL_MAX_W-1:0] rd_b_level;
      logic [ID_W-1:0]      dep_a_node;
   } tpq_store_cmd_type;

   typedef struct packed {
      tpq_entry_type      ent_a;
      tpq_entry_type      ent_b;
      logic [DEPTH_W-1:0] dep_a;
      logic [DEPTH_W-1:0] dep_b;
   } tpq_store_rd_type;

endpackage

@@ rtl/core/tpq_store.sv @@
// Depth memory and lift table (ancestor, max and min weight per level).
// One write port, two registered read ports each. Depends on tpq_pkg.
module tpq_store #(
   parameter int NODE_W = 10,
   parameter int LVL_W  = 4
) (
   input  logic                       clock,
   input  tpq_pkg::tpq_store_cmd_type cmd,
   output tpq_pkg::tpq_store_rd_type  rd
);
   import tpq_pkg::*;

   localparam int TAB_AW    = NODE_W + LVL_W;
   localparam int TAB_DEPTH = 1 << TAB_AW;
   localparam int NODES     = 1 << NODE_W;

   logic [NODE_W-1:0]          anc_mem [TAB_DEPTH];
   logic signed [WEIGHT_W-1:0] max_mem [TAB_DEPTH];
   logic signed [WEIGHT_W-1:0] min_mem [TAB_DEPTH];
   logic [DEPTH_W-1:0]         dep_mem [NODES];

   logic [TAB_AW-1:0]          wr_addr;
   logic [TAB_AW-1:0]          rd_a_addr;
   logic [TAB_AW-1:0]          rd_b_addr;

   logic [NODE_W-1:0]          anc_a_ff;
   logic [NODE_W-1:0]          anc_b_ff;
   logic signed [WEIGHT_W-1:0] max_a_ff;
   logic signed [WEIGHT_W-1:0] max_b_ff;
   logic signed [WEIGHT_W-1:0] min_a_ff;
   logic signed [WEIGHT_W-1:0] min_b_ff;
   logic [DEPTH_W-1:0]         dep_a_ff;
   logic [DEPTH_W-1:0]         dep_b_ff;

   assign wr_addr   = {cmd.wr_node[NODE_W-1:0], cmd.wr_level[LVL_W-1:0]};
   assign rd_a_addr = {cmd.rd_a_node[NODE_W-1:0], cmd.rd_a_level[LVL_W-1:0]};
   assign rd_b_addr = {cmd.rd_b_node[NODE_W-1:0], cmd.rd_b_level[LVL_W-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.tab_wr) begin
         anc_mem[wr_addr] <= cmd.wr_entry.anc[NODE_W-1:0];
         max_mem[wr_addr] <= cmd.wr_entry.wmax;
         min_mem[wr_addr] <= cmd.wr_entry.wmin;
      end
      if (cmd.dep_wr) begin
         dep_mem[cmd.wr_node[NODE_W-1:0]] <= cmd.dep_wr_val;
      end
      anc_a_ff <= anc_mem[rd_a_addr];
      max_a_ff <= max_mem[rd_a_addr];
      min_a_ff <= min_mem[rd_a_addr];
      anc_b_ff <= anc_mem[rd_b_addr];
      max_b_ff <= max_mem[rd_b_addr];
      min_b_ff <= min_mem[rd_b_addr];
      dep_a_ff <= dep_mem[cmd.dep_a_node[NODE_W-1:0]];
      dep_b_ff <= dep_mem[cmd.rd_b_node[NODE_W-1:0]];
   end

   always_comb begin
      rd.ent_a.anc  = ID_W'(anc_a_ff);
      rd.ent_a.wmax = max_a_ff;
      rd.ent_a.wmin = min_a_ff;
      rd.ent_b.anc  = ID_W'(anc_b_ff);
      rd.ent_b.wmax = max_b_ff;
      rd.ent_b.wmin = min_b_ff;
      rd.dep_a      = dep_a_ff;
      rd.dep_b      = dep_b_ff;
   end

endmodule

@@ rtl/core/tree_path_min_max_query.sv @@
// Top level of the tree path min/max query block: sequencer, shared
// min/max compare unit and result register. Depends on tpq_pkg and tpq_store.
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_ready  | mode, node_id, parent_id, edge_weight,
//            |           |                      | end_a, end_b
//   rsp_     | out       | rsp_valid/rsp_ready  | path_min, path_max, path_empty
//
// A load passes ST_LD_DEP, ST_LD_BASE, then ST_LD_RD and ST_LD_WR for each further
// level; a query passes ST_Q_DEP, ST_Q_ORDER, a climb over the set bits of the depth
// difference, a lift over all levels and the tail, and one with equal endpoints goes
// straight to ST_DONE. When MAX_NODES is below 1024, ST_REDUCE first reduces node ids.
// Reset is synchronous and clears the sequencer, its level and the result valid only.
// A finished query waits in place while the previous result is still held.
`include "assert_macros.svh"

module tree_path_min_max_query #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [tpq_pkg::ID_W-1:0]             req_node_id,
   input  logic [tpq_pkg::ID_W-1:0]             req_parent_id,
   input  logic signed [tpq_pkg::WEIGHT_W-1:0]  req_edge_weight,
   input  logic [tpq_pkg::ID_W-1:0]             req_end_a,
   input  logic [tpq_pkg::ID_W-1:0]             req_end_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tpq_pkg::WEIGHT_W-1:0]  rsp_path_min,
   output logic signed [tpq_pkg::WEIGHT_W-1:0]  rsp_path_max,
   output logic                                 rsp_path_empty
);
   import tpq_pkg::*;

   localparam int NODE_W   = (MAX_NODES >= ID_SPAN) ? ID_W : $clog2(MAX_NODES);
   localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam bit NEED_RED = (MAX_NODES < ID_SPAN);
   localparam int RED_TOP  = NEED_RED ? $clog2(ID_SPAN / MAX_NODES) : 0;
   localparam logic [ID_W+1:0]  MOD_BASE = NEED_RED ? (ID_W+2)'(MAX_NODES) : '0;
   localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);

   tpq_state_type              state_ff, state_in;
   logic                       mode_ff, mode_in;
   logic [ID_W-1:0]            id_a_ff, id_a_in;
   logic [ID_W-1:0]            id_b_ff, id_b_in;
   logic [RED_J_W-1:0]         red_j_ff, red_j_in;
   logic [NODE_W-1:0]          u_ff, u_in;
   logic [NODE_W-1:0]          v_ff, v_in;
   logic signed [WEIGHT_W-1:0] w_ff, w_in;
   logic signed [WEIGHT_W-1:0] mx_ff, mx_in;
   logic signed [WEIGHT_W-1:0] mn_ff, mn_in;
   logic [DEPTH_W-1:0]         diff_ff, diff_in;
   logic [LVL_W-1:0]           lvl_ff, lvl_in;
   logic                       empty_ff, empty_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [WEIGHT_W-1:0] rsp_min_ff, rsp_min_in;
   logic signed [WEIGHT_W-1:0] rsp_max_ff, rsp_max_in;
   logic                       rsp_empty_ff, rsp_empty_in;

   tpq_store_cmd_type          cmd;
   tpq_store_rd_type           rd;

   logic [ID_W+1:0]            mod_sh;
   logic [ID_W+1:0]            red_a_ext;
   logic [ID_W+1:0]            red_b_ext;
   logic [ID_W-1:0]            step_a;
   logic [ID_W-1:0]            step_b;
   logic [ID_W-1:0]            pick_a;
   logic [ID_W-1:0]            pick_b;
   logic [SHIFT_W-1:0]         diff_sh;
   logic                       climb_bit;
   logic                       lvl_zero;
   logic                       lvl_last;
   logic                       node_same;
   logic                       anc_diff;
   logic                       rsp_free;
   logic                       cmb_use_b;
   logic signed [WEIGHT_W-1:0] cmp_max;
   logic signed [WEIGHT_W-1:0] cmp_min;

   tpq_store #(
      .NODE_W (NODE_W),
      .LVL_W  (LVL_W)
   ) u_store (
      .clock (clock),
      .cmd   (cmd),
      .rd    (rd)
   );

   // Node ids are reduced modulo MAX_NODES by one conditional subtract per cycle.
   assign mod_sh    = MOD_BASE << red_j_ff;
   assign red_a_ext = (ID_W+2)'(id_a_ff);
   assign red_b_ext = (ID_W+2)'(id_b_ff);
   assign step_a    = (red_a_ext >= mod_sh) ? ID_W'(red_a_ext - mod_sh) : id_a_ff;
   assign step_b    = (red_b_ext >= mod_sh) ? ID_W'(red_b_ext - mod_sh) : id_b_ff;
   assign pick_a    = (req_mode == MODE_QUERY) ? req_end_a : req_node_id;
   assign pick_b    = (req_mode == MODE_QUERY) ? req_end_b : req_parent_id;

   assign diff_sh   = SHIFT_W'(diff_ff) >> lvl_ff;
   assign climb_bit = diff_sh[0];
   assign lvl_zero  = (lvl_ff == '0);
   assign lvl_last  = (lvl_ff == LVL_LAST);
   assign node_same = (u_ff == v_ff);
   assign anc_diff  = (rd.ent_a.anc != rd.ent_b.anc);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmp_max = mx_ff;
      cmp_min = mn_ff;
      if (rd.ent_a.wmax > cmp_max) begin
         cmp_max = rd.ent_a.wmax;
      end
      if (rd.ent_a.wmin < cmp_min) begin
         cmp_min = rd.ent_a.wmin;
      end
      if (cmb_use_b && (rd.ent_b.wmax > cmp_max)) begin
         cmp_max = rd.ent_b.wmax;
      end
      if (cmb_use_b && (rd.ent_b.wmin < cmp_min)) begin
         cmp_min = rd.ent_b.wmin;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (NEED_RED) begin
                  state_in = ST_REDUCE;
               end else if (req_mode == MODE_QUERY) begin
                  state_in = ST_Q_DEP;
               end else begin
                  state_in = ST_LD_DEP;
               end
            end
         end
         ST_REDUCE: begin
            if (red_j_ff == '0) begin
               state_in = (mode_ff == MODE_QUERY) ? ST_Q_DEP : ST_LD_DEP;
            end
         end
         ST_LD_DEP:  state_in = ST_LD_BASE;
         ST_LD_BASE: state_in = (LEVELS == 1) ? ST_IDLE : ST_LD_RD;
         ST_LD_RD:   state_in = ST_LD_WR;
         ST_LD_WR:   state_in = lvl_last ? ST_IDLE : ST_LD_RD;
         ST_Q_DEP:   state_in = node_same ? ST_DONE : ST_Q_ORDER;
         ST_Q_ORDER: state_in = ST_Q_CLIMB;
         ST_Q_CLIMB: begin
            if (climb_bit) begin
               state_in = ST_Q_CLIMB_USE;
            end else if (lvl_zero) begin
               state_in = ST_Q_LIFT_RD;
            end
         end
         ST_Q_CLIMB_USE: state_in = lvl_zero ? ST_Q_LIFT_RD : ST_Q_CLIMB;
         ST_Q_LIFT_RD:   state_in = ST_Q_LIFT_USE;
         ST_Q_LIFT_USE:  state_in = lvl_zero ? ST_Q_TAIL_RD : ST_Q_LIFT_RD;
         ST_Q_TAIL_RD:   state_in = node_same ? ST_DONE : ST_Q_TAIL_USE;
         ST_Q_TAIL_USE:  state_in = ST_DONE;
         ST_DONE:        state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      id_a_in      = id_a_ff;
      id_b_in      = id_b_ff;
      red_j_in     = red_j_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      mx_in        = mx_ff;
      mn_in        = mn_ff;
      diff_in      = diff_ff;
      lvl_in       = lvl_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_empty_in = rsp_empty_ff;
      cmb_use_b    = 1'b0;

      cmd            = '0;
      cmd.rd_a_node  = ID_W'(u_ff);
      cmd.rd_a_level = LVL_MAX_W'(lvl_ff);
      cmd.rd_b_node  = ID_W'(v_ff);
      cmd.rd_b_level = LVL_MAX_W'(lvl_ff);
      cmd.dep_a_node = ID_W'(u_ff);
      cmd.wr_node    = ID_W'(u_ff);
      cmd.wr_level   = LVL_MAX_W'(lvl_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               id_a_in  = pick_a;
               id_b_in  = pick_b;
               w_in     = req_edge_weight;
               red_j_in = RED_J_W'(RED_TOP);
               u_in     = pick_a[NODE_W-1:0];
               v_in     = pick_b[NODE_W-1:0];
            end
         end
         ST_REDUCE: begin
            id_a_in  = step_a;
            id_b_in  = step_b;
            u_in     = step_a[NODE_W-1:0];
            v_in     = step_b[NODE_W-1:0];
            red_j_in = red_j_ff - 1'b1;
         end
         ST_LD_DEP: begin
            cmd.dep_a_node = ID_W'(v_ff);
         end
         ST_LD_BASE: begin
            cmd.tab_wr       = 1'b1;
            cmd.dep_wr       = 1'b1;
            cmd.wr_level     = '0;
            cmd.wr_entry.anc = ID_W'(v_ff);
            if (node_same) begin
               cmd.dep_wr_val    = '0;
               cmd.wr_entry.wmax = WEIGHT_NINF;
               cmd.wr_entry.wmin = WEIGHT_INF;
            end else begin
               cmd.dep_wr_val    = rd.dep_a + 1'b1;
               cmd.wr_entry.wmax = w_ff;
               cmd.wr_entry.wmin = w_ff;
            end
            mx_in  = cmd.wr_entry.wmax;
            mn_in  = cmd.wr_entry.wmin;
            lvl_in = '0;
            if (LEVELS > 1) begin
               lvl_in = LVL_W'(1);
            end
         end
         ST_LD_RD: begin
            cmd.rd_a_node  = ID_W'(v_ff);
            cmd.rd_a_level = LVL_MAX_W'(lvl_ff - 1'b1);
         end
         ST_LD_WR: begin
            cmd.tab_wr        = 1'b1;
            cmd.wr_entry.anc  = rd.ent_a.anc;
            cmd.wr_entry.wmax = cmp_max;
            cmd.wr_entry.wmin = cmp_min;
            mx_in             = cmp_max;
            mn_in             = cmp_min;
            v_in              = rd.ent_a.anc[NODE_W-1:0];
            if (!lvl_last) begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         ST_Q_DEP: begin
            mx_in    = WEIGHT_NINF;
            mn_in    = WEIGHT_INF;
            empty_in = node_same;
         end
         ST_Q_ORDER: begin
            lvl_in = LVL_LAST;
            if (rd.dep_a > rd.dep_b) begin
               u_in    = v_ff;
               v_in    = u_ff;
               diff_in = rd.dep_a - rd.dep_b;
            end else begin
               diff_in = rd.dep_b - rd.dep_a;
            end
         end
         ST_Q_CLIMB: begin
            cmd.rd_a_node = ID_W'(v_ff);
            if (!climb_bit) begin
               lvl_in = lvl_zero ? LVL_LAST : lvl_ff - 1'b1;
            end
         end
         ST_Q_CLIMB_USE: begin
            mx_in  = cmp_max;
            mn_in  = cmp_min;
            v_in   = rd.ent_a.anc[NODE_W-1:0];
            lvl_in = lvl_zero ? LVL_LAST : lvl_ff - 1'b1;
         end
         ST_Q_LIFT_RD: begin
         end
         ST_Q_LIFT_USE: begin
            if (anc_diff) begin
               cmb_use_b = 1'b1;
               mx_in     = cmp_max;
               mn_in     = cmp_min;
               u_in      = rd.ent_a.anc[NODE_W-1:0];
               v_in      = rd.ent_b.anc[NODE_W-1:0];
            end
            if (!lvl_zero) begin
               lvl_in = lvl_ff - 1'b1;
            end
         end
         ST_Q_TAIL_RD: begin
         end
         ST_Q_TAIL_USE: begin
            cmb_use_b = 1'b1;
            mx_in     = cmp_max;
            mn_in     = cmp_min;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = mn_ff;
               rsp_max_in   = mx_ff;
               rsp_empty_in = empty_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lvl_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lvl_ff       <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      id_a_ff      <= id_a_in;
      id_b_ff      <= id_b_in;
      red_j_ff     <= red_j_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      w_ff         <= w_in;
      mx_ff        <= mx_in;
      mn_ff        <= mn_in;
      diff_ff      <= diff_in;
      empty_ff     <= empty_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_min   = rsp_min_ff;
   assign rsp_path_max   = rsp_max_ff;
   assign rsp_path_empty = rsp_empty_ff;

   `ASSERT_NEXT(a_done_delivers, clock, reset, (state_ff == ST_DONE) && rsp_free, rsp_valid_ff)
   `ASSERT_HOLDS(a_empty_sentinels, clock, reset, rsp_valid && rsp_path_empty,
      (rsp_path_min == WEIGHT_INF) && (rsp_path_max == WEIGHT_NINF))
   `ASSERT_HOLDS(a_level_range, clock, reset, 1'b1, lvl_ff <= LVL_LAST)

endmodule
